// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/bpfm_pkg.sv -----
// ----------------------------------------------------------------------------
// Buffer pool frame manager package
// Request and response words, codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam int unsigned FRAMES_DEF       = 16;
  localparam int unsigned PAGE_ID_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_PIN   = 2'd0,
    OP_UNPIN = 2'd1,
    OP_FREE  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_VICTIM = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_UNPINNED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] page_id;
    logic        empty_page;
    logic        dirty_hint;
    logic        hate;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] frame_index;
    logic       read_request;
    logic       write_request;
    logic       dealloc_request;
    logic [4:0] free_frames;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic update;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage

// ----- hw/rtl/bpfm_datapath.sv -----
// ----------------------------------------------------------------------------
// Buffer pool frame manager datapath
// Frame table memory, scan captures, decision logic and list rank update.
// ----------------------------------------------------------------------------
module bpfm_datapath #(
  parameter int unsigned FRAMES       = 16,
  parameter int unsigned PAGE_ID_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpfm_pkg::req_t    req_i,
  input  bpfm_pkg::dp_cmd_t cmd_i,
  output bpfm_pkg::dp_sts_t sts_o,
  output bpfm_pkg::rsp_t    rsp_o
);
  import bpfm_pkg::*;

  localparam int unsigned IDXW = $clog2(FRAMES);
  localparam int unsigned CNTW = $clog2(FRAMES + 1);

  // One frame table entry; rank is the place within its list.
  typedef struct packed {
    logic [PAGE_ID_BITS-1:0] page;
    logic [7:0]              pin;
    logic                    dirty;
    logic                    lst;
    logic [IDXW-1:0]         rank;
  } entry_t;

  entry_t mem [FRAMES];
  entry_t rdata_q;

  req_t                    req_q;
  logic [PAGE_ID_BITS-1:0] pg;
  logic [CNTW-1:0]         cnt_q;
  logic                    rv_q;
  logic [IDXW-1:0]         ridx_q;
  logic [FRAMES-1:0]       valid_q, valid_d;
  logic [CNTW-1:0]         hate_cnt_q, hate_cnt_d;
  logic [CNTW-1:0]         love_cnt_q, love_cnt_d;
  logic [CNTW-1:0]         used_cnt_q, used_cnt_d;

  logic                    hit_q, emp_q;
  logic [IDXW-1:0]         hf_q, ef_q, hv_q, lv_q;
  entry_t                  he_q;

  logic [IDXW-1:0]         tgt_q, tgt_d;
  logic                    tgt_we_q, tgt_we_d;
  entry_t                  ne_q, ne_d;
  logic                    rem_q, rem_d;
  logic                    rem_lst_q, rem_lst_d;
  logic [IDXW-1:0]         rem_rank_q, rem_rank_d;
  rsp_t                    rsp_q, rsp_d;

  logic                    mem_re, mem_we;
  entry_t                  mem_wdata;
  logic                    rd_valid, unl, dec;

  assign pg = PAGE_ID_BITS'(req_q.page_id);

  // Read address runs over all frames during the scan and update passes.
  assign mem_re = (cmd_i.scan || cmd_i.update) && (cnt_q < CNTW'(FRAMES));
  assign sts_o.last = (cnt_q == CNTW'(FRAMES));
  assign rd_valid = valid_q[ridx_q];
  assign unl = rd_valid && (rdata_q.pin == 8'd0);

  // An unpinned entry behind the removed one on the same list moves up.
  assign dec = rem_q && unl && (rdata_q.lst == rem_lst_q) &&
               (rdata_q.rank > rem_rank_q) && (ridx_q != tgt_q);

  // Update pass writes back the entry read in the previous cycle.
  always_comb begin
    mem_we    = cmd_i.update && rv_q && ((tgt_we_q && ridx_q == tgt_q) || dec);
    mem_wdata = rdata_q;
    if (ridx_q == tgt_q) begin
      mem_wdata = ne_q;
    end else begin
      mem_wdata.rank = rdata_q.rank - IDXW'(1);
    end
  end

  // Frame table memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ridx_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[cnt_q[IDXW-1:0]];
    end
  end

  // Pass counter and read tag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rv_q   <= 1'b0;
      ridx_q <= '0;
    end else begin
      if (cmd_i.load || cmd_i.decide) begin
        cnt_q <= '0;
      end else if (mem_re) begin
        cnt_q <= cnt_q + CNTW'(1);
      end
      rv_q   <= mem_re;
      ridx_q <= cnt_q[IDXW-1:0];
    end
  end

  // Scan captures: hit, lowest empty frame and both victim candidates.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      hit_q <= 1'b0;
      emp_q <= 1'b0;
      hf_q  <= '0;
      ef_q  <= '0;
      hv_q  <= '0;
      lv_q  <= '0;
    end else if (cmd_i.scan && rv_q) begin
      if (rd_valid && rdata_q.page == pg && !hit_q) begin
        hit_q <= 1'b1;
        hf_q  <= ridx_q;
        he_q  <= rdata_q;
      end
      if (!rd_valid && !emp_q) begin
        emp_q <= 1'b1;
        ef_q  <= ridx_q;
      end
      if (unl && rdata_q.lst && rdata_q.rank == '0) begin
        hv_q <= ridx_q;
      end
      if (unl && !rdata_q.lst && CNTW'(rdata_q.rank) == love_cnt_q - CNTW'(1)) begin
        lv_q <= ridx_q;
      end
    end
  end

  // Decision on the captured scan results.
  always_comb begin
    logic dsum;
    dsum       = he_q.dirty | req_q.dirty_hint;
    rsp_d      = '0;
    tgt_d      = hf_q;
    tgt_we_d   = 1'b0;
    ne_d       = he_q;
    rem_d      = 1'b0;
    rem_lst_d  = he_q.lst;
    rem_rank_d = he_q.rank;
    valid_d    = valid_q;
    hate_cnt_d = hate_cnt_q;
    love_cnt_d = love_cnt_q;
    used_cnt_d = used_cnt_q;
    rsp_d.status = ST_OK;
    case (opcode_e'(req_q.opcode))
      OP_PIN: begin
        if (hit_q) begin
          tgt_we_d = 1'b1;
          rsp_d.frame_index = 4'(hf_q);
          if (he_q.pin == 8'd0) begin
            rem_d = 1'b1;
            if (he_q.lst) begin
              hate_cnt_d = hate_cnt_q - CNTW'(1);
            end else begin
              love_cnt_d = love_cnt_q - CNTW'(1);
            end
          end
          if (he_q.pin != 8'hFF) begin
            ne_d.pin = he_q.pin + 8'd1;
          end
        end else begin
          tgt_we_d   = 1'b1;
          ne_d.page  = pg;
          ne_d.pin   = 8'd1;
          ne_d.dirty = 1'b0;
          if (emp_q) begin
            tgt_d      = ef_q;
            used_cnt_d = used_cnt_q + CNTW'(1);
            valid_d[ef_q] = 1'b1;
          end else if (hate_cnt_q != '0) begin
            tgt_d      = hv_q;
            rem_d      = 1'b1;
            rem_lst_d  = 1'b1;
            rem_rank_d = '0;
            hate_cnt_d = hate_cnt_q - CNTW'(1);
          end else if (love_cnt_q != '0) begin
            tgt_d      = lv_q;
            love_cnt_d = love_cnt_q - CNTW'(1);
          end else begin
            tgt_we_d     = 1'b0;
            rsp_d.status = ST_NO_VICTIM;
          end
          if (tgt_we_d) begin
            rsp_d.frame_index  = 4'(tgt_d);
            rsp_d.read_request = !req_q.empty_page;
          end
        end
      end
      OP_UNPIN: begin
        if (!hit_q) begin
          rsp_d.status = ST_NOT_FOUND;
        end else if (he_q.pin == 8'd0) begin
          rsp_d.status      = ST_UNPINNED;
          rsp_d.frame_index = 4'(hf_q);
        end else begin
          tgt_we_d          = 1'b1;
          rsp_d.frame_index = 4'(hf_q);
          ne_d.pin          = he_q.pin - 8'd1;
          ne_d.dirty        = dsum;
          if (he_q.pin == 8'd1) begin
            rsp_d.write_request = dsum;
            ne_d.dirty = 1'b0;
            ne_d.lst   = req_q.hate;
            if (req_q.hate) begin
              ne_d.rank  = IDXW'(hate_cnt_q);
              hate_cnt_d = hate_cnt_q + CNTW'(1);
            end else begin
              ne_d.rank  = IDXW'(love_cnt_q);
              love_cnt_d = love_cnt_q + CNTW'(1);
            end
          end
        end
      end
      OP_FREE: begin
        if (!hit_q) begin
          rsp_d.status = ST_NOT_FOUND;
        end else begin
          rsp_d.frame_index     = 4'(hf_q);
          rsp_d.dealloc_request = 1'b1;
          valid_d[hf_q]         = 1'b0;
          if (used_cnt_q != '0) begin
            used_cnt_d = used_cnt_q - CNTW'(1);
          end
          if (he_q.pin == 8'd0) begin
            rem_d = 1'b1;
            if (he_q.lst) begin
              hate_cnt_d = hate_cnt_q - CNTW'(1);
            end else begin
              love_cnt_d = love_cnt_q - CNTW'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
    rsp_d.free_frames = 5'(CNTW'(FRAMES) - used_cnt_d);
  end

  // Pool state applied at the decision step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      hate_cnt_q <= '0;
      love_cnt_q <= '0;
      used_cnt_q <= '0;
      tgt_we_q   <= 1'b0;
      rem_q      <= 1'b0;
    end else if (cmd_i.decide) begin
      valid_q    <= valid_d;
      hate_cnt_q <= hate_cnt_d;
      love_cnt_q <= love_cnt_d;
      used_cnt_q <= used_cnt_d;
      tgt_we_q   <= tgt_we_d;
      rem_q      <= rem_d;
    end
  end

  // Plan for the update pass and the response word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      tgt_q      <= tgt_d;
      ne_q       <= ne_d;
      rem_lst_q  <= rem_lst_d;
      rem_rank_q <= rem_rank_d;
      rsp_q      <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- hw/rtl/bpfm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Buffer pool frame manager controller
// Sequences scan, decision, update and response for each request word.
// ----------------------------------------------------------------------------
module bpfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bpfm_pkg::dp_sts_t sts_i,
  output bpfm_pkg::dp_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import bpfm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_UPDATE = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        if (sts_i.last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

// ----- hw/rtl/buffer_pool_frame_manager_top.sv -----
// ----------------------------------------------------------------------------
// Buffer pool frame manager
// Maps page ids onto buffer frames with hate-queue and love-stack replacement.
// ----------------------------------------------------------------------------
// Each word takes two passes over the frame table memory, a scan and an
// update, one entry read per cycle, before the done strobe; the receiver
// cannot stall. Busy drops after the strobe, so a new word is taken only
// once the last one is through.
// Reset empties the pool at once: valid bits and list counts clear.
module buffer_pool_frame_manager_top #(
  parameter int unsigned FRAMES       = bpfm_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_ID_BITS = bpfm_pkg::PAGE_ID_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bpfm_pkg::req_t req_i,
  output logic           done_o,
  output bpfm_pkg::rsp_t rsp_o
);
  import bpfm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bpfm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !busy),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  bpfm_datapath #(
    .FRAMES       (FRAMES),
    .PAGE_ID_BITS (PAGE_ID_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- hw/rtl/bpfm_checker.sv -----
// ----------------------------------------------------------------------------
// Buffer pool frame manager checker
// Port-level properties of the request and response sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpfm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input bpfm_pkg::rsp_t rsp_o
);
  import bpfm_pkg::*;

  // An accepted word keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // The strobe comes only while a word is in work.
  `ASSERT_IMPL(a_done_busy, clk_i, rst_ni, done_o, busy)
  // The block is free again right after the strobe.
  `ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // A failed pin means every frame holds a page.
  `ASSERT_IMPL(a_novictim_full, clk_i, rst_ni,
    done_o && rsp_o.status == ST_NO_VICTIM, rsp_o.free_frames == 5'd0)
  // A deallocation is only asked for on a successful free.
  `ASSERT_IMPL(a_dealloc_ok, clk_i, rst_ni,
    done_o && rsp_o.dealloc_request, rsp_o.status == ST_OK && !rsp_o.read_request)

endmodule

bind buffer_pool_frame_manager_top bpfm_checker u_bpfm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
